### rtl/core/sotr_pkg.sv
`timescale 1ns / 1ps
package sotr_pkg;
	localparam int DEPTH = 32;
	localparam int AW = $clog2(DEPTH);
	localparam int MAX_RES = 32;
	localparam int QD = 2;

	typedef enum logic [1:0] {
		FN_PUSH  = 2'd0,
		FN_DRAIN = 2'd1,
		FN_STATS = 2'd2,
		FN_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		K_ACK   = 2'd0,
		K_REC   = 2'd1,
		K_STAT  = 2'd2,
		K_EMPTY = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_DRAIN,
		BS_STATS
	} bstate_t;

	localparam logic [1:0] LVL_INFO = 2'd2;
	localparam logic [15:0] NOTE_MAX = 16'hFFFF;

	// Classified command handed from the front to the back.
	typedef struct packed {
		func_t        func;
		logic [1:0]   level;
		logic [31:0]  pid;
		logic [7:0]   subsystem;
		logic [63:0]  payload;
		logic [47:0]  time_ms;
		logic [63:0]  after_seq;
		logic [5:0]   cap;
	} cmd_t;

	typedef struct packed {
		kind_t        kind;
		logic [63:0]  seq;
		logic [47:0]  timestamp;
		logic [1:0]   rec_level;
		logic [31:0]  rec_pid;
		logic [7:0]   rec_subsystem;
		logic [63:0]  rec_payload;
		logic [15:0]  dropped_note;
		logic         console;
		logic         last;
		logic [2:0]   stat_index;
		logic [63:0]  stat_value;
	} res_t;
endpackage

### rtl/core/sotr_front.sv
`timescale 1ns / 1ps
module sotr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        func,
	input  logic [2:0]        level,
	input  logic signed [31:0] pid,
	input  logic [7:0]        subsystem,
	input  logic [63:0]       payload,
	input  logic [47:0]       time_ms,
	input  logic [63:0]       after_seq,
	input  logic [6:0]        max_count,
	output logic              q_valid,
	input  logic              q_pop,
	output sotr_pkg::cmd_t    q_cmd
);
	import sotr_pkg::*;

	cmd_t mem_q [QD];
	logic [$clog2(QD)-1:0] wp_q, rp_q;
	logic [$clog2(QD):0] cnt_q;
	cmd_t c;
	logic push;

	always_comb begin
		c.func = func_t'(func);
		c.level = (level > 3'd3) ? LVL_INFO : level[1:0];
		c.pid = pid;
		c.subsystem = subsystem;
		c.payload = payload;
		c.time_ms = time_ms;
		c.after_seq = after_seq;
		c.cap = (max_count > 7'(MAX_RES)) ? 6'(MAX_RES) : max_count[5:0];
	end

	assign in_ready = cnt_q != ($clog2(QD)+1)'(QD);
	// Unused function codes are dropped here and never reach the back.
	assign push = in_valid && in_ready && (func != FN_NONE);
	assign q_valid = cnt_q != '0;
	assign q_cmd = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (q_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + ($clog2(QD)+1)'(push) - ($clog2(QD)+1)'(q_pop);
		end
	end
endmodule

### rtl/core/sotr_back.sv
`timescale 1ns / 1ps
module sotr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     echo_level,
	input  logic           q_valid,
	output logic           q_pop,
	input  sotr_pkg::cmd_t q_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output sotr_pkg::res_t res
);
	import sotr_pkg::*;

	logic [63:0] s_seq [DEPTH];
	logic [47:0] s_time [DEPTH];
	logic [1:0]  s_lvl [DEPTH];
	logic [31:0] s_pid [DEPTH];
	logic [7:0]  s_sub [DEPTH];
	logic [63:0] s_pay [DEPTH];
	logic [DEPTH-1:0] used_q;

	logic [63:0] next_seq_q, drops_q, emitted_q;
	logic [63:0] lvl_cnt_q [4];
	logic [15:0] dsd_q;
	logic [AW:0] used_cnt_q;

	bstate_t st_q, st_d;
	logic [63:0] s_q, newest_q;
	logic [5:0] n_q, cap_q;
	logic [2:0] si_q;
	logic ov_q;
	res_t res_q;

	logic can_out;
	assign can_out = !ov_q || out_ready;
	assign out_valid = ov_q;
	assign res = res_q;

	logic [AW-1:0] wslot, rslot;
	logic [63:0] nseq, oldest, start;
	assign nseq = next_seq_q + 64'd1;
	assign wslot = next_seq_q[AW-1:0];
	assign rslot = AW'(s_q - 64'd1);
	assign oldest = (next_seq_q > 64'(DEPTH)) ? next_seq_q - 64'(DEPTH) + 64'd1 : 64'd1;
	assign start = (q_cmd.after_seq >= oldest) ? q_cmd.after_seq + 64'd1 : oldest;

	logic idle_take, hit, drain_end;
	assign idle_take = (st_q == BS_IDLE) && q_valid && can_out;
	assign q_pop = idle_take;
	assign hit = used_q[rslot] && (s_seq[rslot] == s_q);
	assign drain_end = (s_q >= newest_q) || (hit && (n_q + 6'd1 == cap_q));

	always_comb begin
		st_d = st_q;
		case (st_q)
			BS_IDLE: if (idle_take) begin
				if (q_cmd.func == FN_STATS) st_d = BS_STATS;
				else if (q_cmd.func == FN_DRAIN && q_cmd.after_seq < next_seq_q &&
						q_cmd.cap != '0)
					st_d = BS_DRAIN;
			end
			BS_DRAIN: if (can_out && drain_end && (hit || n_q != 0)) st_d = BS_IDLE;
				else if (can_out && drain_end) st_d = BS_IDLE;
			BS_STATS: if (can_out && si_q == 3'd6) st_d = BS_IDLE;
			default: st_d = BS_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (idle_take && q_cmd.func == FN_PUSH) begin
			s_seq[wslot] <= nseq;
			s_time[wslot] <= q_cmd.time_ms;
			s_lvl[wslot] <= q_cmd.level;
			s_pid[wslot] <= q_cmd.pid;
			s_sub[wslot] <= q_cmd.subsystem;
			s_pay[wslot] <= q_cmd.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BS_IDLE;
			used_q <= '0;
			used_cnt_q <= '0;
			next_seq_q <= '0;
			drops_q <= '0;
			emitted_q <= '0;
			dsd_q <= '0;
			for (int i = 0; i < 4; i++) lvl_cnt_q[i] <= '0;
			ov_q <= 1'b0;
			s_q <= '0;
			newest_q <= '0;
			n_q <= '0;
			cap_q <= '0;
			si_q <= '0;
			res_q <= '0;
		end else begin
			st_q <= st_d;
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (st_q)
				BS_IDLE: if (idle_take) begin
					res_q <= '0;
					case (q_cmd.func)
						FN_PUSH: begin
							if (used_q[wslot]) begin
								if (drops_q != '1) drops_q <= drops_q + 64'd1;
								if (dsd_q != NOTE_MAX) dsd_q <= dsd_q + 16'd1;
							end else begin
								used_cnt_q <= used_cnt_q + 1'b1;
							end
							used_q[wslot] <= 1'b1;
							next_seq_q <= nseq;
							emitted_q <= emitted_q + 64'd1;
							lvl_cnt_q[q_cmd.level] <= lvl_cnt_q[q_cmd.level] + 64'd1;
							res_q.kind <= K_ACK;
							res_q.seq <= nseq;
							res_q.console <= q_cmd.level <= echo_level;
							res_q.last <= 1'b1;
							ov_q <= 1'b1;
						end
						FN_DRAIN: begin
							if (q_cmd.after_seq < next_seq_q && q_cmd.cap != 0) begin
								s_q <= start;
								newest_q <= next_seq_q;
								cap_q <= q_cmd.cap;
								n_q <= '0;
							end else begin
								res_q.kind <= K_EMPTY;
								res_q.last <= 1'b1;
								ov_q <= 1'b1;
							end
						end
						FN_STATS: si_q <= '0;
						default: ;
					endcase
				end
				BS_DRAIN: if (can_out) begin
					s_q <= s_q + 64'd1;
					res_q <= '0;
					if (hit) begin
						n_q <= n_q + 6'd1;
						res_q.kind <= K_REC;
						res_q.seq <= s_q;
						res_q.timestamp <= s_time[rslot];
						res_q.rec_level <= s_lvl[rslot];
						res_q.rec_pid <= s_pid[rslot];
						res_q.rec_subsystem <= s_sub[rslot];
						res_q.rec_payload <= s_pay[rslot];
						res_q.dropped_note <= (n_q == 0) ? dsd_q : 16'd0;
						res_q.last <= drain_end;
						if (n_q == 0) dsd_q <= '0;
						ov_q <= 1'b1;
					end else if (drain_end && n_q == 0) begin
						res_q.kind <= K_EMPTY;
						res_q.last <= 1'b1;
						ov_q <= 1'b1;
					end
				end
				BS_STATS: if (can_out) begin
					si_q <= si_q + 3'd1;
					res_q <= '0;
					res_q.kind <= K_STAT;
					res_q.stat_index <= si_q;
					res_q.last <= si_q == 3'd6;
					case (si_q)
						3'd0: res_q.stat_value <= emitted_q;
						3'd1: res_q.stat_value <= drops_q;
						3'd2: res_q.stat_value <= lvl_cnt_q[0];
						3'd3: res_q.stat_value <= lvl_cnt_q[1];
						3'd4: res_q.stat_value <= lvl_cnt_q[2];
						3'd5: res_q.stat_value <= lvl_cnt_q[3];
						default: res_q.stat_value <= 64'(used_cnt_q);
					endcase
					ov_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end
endmodule

### rtl/core/sequenced_overwrite_trace_ring.sv
`timescale 1ns / 1ps
// Push: one word per cycle unless back is busy or stalled; ack leaves the result register.
// Drain: scans one sequence number at a time, up to 32, until the cap; stats: seven records.
// Rate is set by the single back-end sequencer that owns the slot arrays.
// Reset clears control, counters and slot valid bits at once; console level returns to info.
module sequenced_overwrite_trace_ring (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [2:0]         level,
	input  logic signed [31:0] pid,
	input  logic [7:0]         subsystem,
	input  logic [63:0]        payload,
	input  logic [47:0]        time_ms,
	input  logic [63:0]        after_seq,
	input  logic [6:0]         max_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic [63:0]        seq,
	output logic [47:0]        timestamp,
	output logic [1:0]         rec_level,
	output logic signed [31:0] rec_pid,
	output logic [7:0]         rec_subsystem,
	output logic [63:0]        rec_payload,
	output logic [15:0]        dropped_note,
	output logic               console,
	output logic               last,
	output logic [2:0]         stat_index,
	output logic [63:0]        stat_value
);
	import sotr_pkg::*;

	logic [1:0] echo_level_q;
	logic q_valid, q_pop;
	cmd_t q_cmd;
	res_t r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) echo_level_q <= LVL_INFO;
		else if (cfg_we) echo_level_q <= cfg_wdata;
	end

	sotr_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .func, .level, .pid, .subsystem,
		.payload, .time_ms, .after_seq, .max_count, .q_valid, .q_pop, .q_cmd
	);

	sotr_back u_back (
		.clk, .arst_n, .echo_level(echo_level_q), .q_valid, .q_pop, .q_cmd,
		.out_valid, .out_ready, .res(r)
	);

	assign kind = r.kind;
	assign seq = r.seq;
	assign timestamp = r.timestamp;
	assign rec_level = r.rec_level;
	assign rec_pid = r.rec_pid;
	assign rec_subsystem = r.rec_subsystem;
	assign rec_payload = r.rec_payload;
	assign dropped_note = r.dropped_note;
	assign console = r.console;
	assign last = r.last;
	assign stat_index = r.stat_index;
	assign stat_value = r.stat_value;
endmodule
